>>> rtl/fsn_pkg.sv
// ----------------------------------------------------------------------------
// fsn_pkg: shared types and constants for the fractal simplex noise block
// widths, fixed-point constants, permutation and gradient tables, states
// ----------------------------------------------------------------------------
package fsn_pkg;

  localparam int unsigned MAX_OCTAVES = 8;
  localparam int unsigned OCT_W       = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned MUL_W       = 34;
  localparam int unsigned PROD_W      = 2 * MUL_W;
  localparam int unsigned DIV_W       = 60;
  localparam int unsigned DIV_STEPS   = DIV_W / 4;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int unsigned OFS_W       = 27;
  localparam int unsigned DOT_W       = 29;
  localparam int unsigned ACC_W       = 36;

  localparam logic signed [OFS_W-1:0] ONE_Q24    = 27'sd16777216;
  localparam logic signed [OFS_W-1:0] G3_Q24     = 27'sd2796203;
  localparam logic signed [OFS_W-1:0] G3X2_Q24   = 27'sd5592405;
  localparam logic signed [OFS_W-1:0] G3X3M1_Q24 = -27'sd8388608;
  localparam logic signed [32:0]      FALLOFF_Q24 = 33'sd10066330;
  localparam logic [7:0]              SEED_MIX    = 8'hB9;
  localparam logic [7:0]              LAYER_B_SEED = 8'd100;
  localparam logic [23:0]             FREQ_RESET  = 24'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED, CFG_AMP_A, CFG_FREQ_A, CFG_OCT_A, CFG_AMP_B, CFG_FREQ_B, CFG_OCT_B
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LAYER, ST_SCL_X, ST_SCL_Y, ST_SCL_Z, ST_SCL_END, ST_DIV_S, ST_SKEW,
    ST_DIV_U, ST_ORDER, ST_CORNER, ST_HASH0, ST_HASH1, ST_HASH2, ST_DX, ST_DY, ST_DZ,
    ST_DSUM, ST_FALL, ST_T2, ST_T4, ST_N, ST_WT, ST_WTW, ST_OUT
  } fsn_state_e;

  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
    8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
    8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
    8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
    8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
    8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
    8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
    8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
    8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
    8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
    8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
    8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
    8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
    8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
    8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
    8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
    8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
    8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
    8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  localparam logic signed [1:0] GRAD_X [16] = '{
    2'sd1,-2'sd1,2'sd1,-2'sd1,2'sd1,-2'sd1,2'sd1,-2'sd1,
    2'sd0,2'sd0,2'sd0,2'sd0,2'sd1,-2'sd1,2'sd0,2'sd0};
  localparam logic signed [1:0] GRAD_Y [16] = '{
    2'sd1,2'sd1,-2'sd1,-2'sd1,2'sd0,2'sd0,2'sd0,2'sd0,
    2'sd1,-2'sd1,2'sd1,-2'sd1,2'sd1,2'sd1,-2'sd1,-2'sd1};
  localparam logic signed [1:0] GRAD_Z [16] = '{
    2'sd0,2'sd0,2'sd0,2'sd0,2'sd1,2'sd1,-2'sd1,-2'sd1,
    2'sd1,2'sd1,-2'sd1,-2'sd1,2'sd0,2'sd0,2'sd1,-2'sd1};

  // gradient component times offset, component is -1, 0 or +1
  function automatic logic signed [DOT_W-1:0] grad_term(input logic signed [1:0] g,
                                                        input logic signed [OFS_W-1:0] v);
    logic signed [DOT_W-1:0] ve;
    ve = DOT_W'(v);
    if (g == 2'sd1) begin
      grad_term = ve;
    end else if (g == -2'sd1) begin
      grad_term = -ve;
    end else begin
      grad_term = '0;
    end
  endfunction

endpackage

>>> rtl/fsn_mul.sv
// ----------------------------------------------------------------------------
// fsn_mul: shared signed multiplier
// one signed product per cycle, result registered
// ----------------------------------------------------------------------------
module fsn_mul (
  input  logic                                 clk_i,
  input  logic signed [fsn_pkg::MUL_W-1:0]     a_i,
  input  logic signed [fsn_pkg::MUL_W-1:0]     b_i,
  output logic signed [fsn_pkg::PROD_W-1:0]    p_o
);
  import fsn_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

>>> rtl/fsn_div3.sv
// ----------------------------------------------------------------------------
// fsn_div3: floor division by three
// radix-16 digit recurrence on the magnitude, sign and floor fixed at the end
// ----------------------------------------------------------------------------
module fsn_div3 (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [fsn_pkg::DIV_W-1:0]   dividend_i,
  output logic                               done_o,
  output logic signed [fsn_pkg::DIV_W-1:0]   quotient_o
);
  import fsn_pkg::*;

  logic [DIV_W-1:0]     mag_q, quo_q;
  logic [1:0]           rem_q, rem_d;
  logic [3:0]           qbits;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 neg_q, busy_q, done_q;

  always_comb begin
    logic [2:0] r;
    rem_d = rem_q;
    qbits = '0;
    for (int k = 0; k < 4; k++) begin
      r = {rem_d, mag_q[DIV_W-1-k]};
      if (r >= 3'd3) begin
        qbits[3-k] = 1'b1;
        rem_d      = 2'(r - 3'd3);
      end else begin
        rem_d = r[1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= dividend_i[DIV_W-1] ? DIV_W'(-dividend_i) : DIV_W'(dividend_i);
      neg_q <= dividend_i[DIV_W-1];
      quo_q <= '0;
      rem_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[DIV_W-5:0], 4'b0};
      quo_q <= {quo_q[DIV_W-5:0], qbits};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(quo_q + DIV_W'(rem_q != 2'd0)) : $signed(quo_q);

endmodule

>>> rtl/fractal_simplex_noise_3d.sv
// ----------------------------------------------------------------------------
// fractal_simplex_noise_3d: two-layer fractal 3d simplex noise
// sequencer around one shared multiplier and one divide-by-three unit
// ----------------------------------------------------------------------------
// A point is taken when start_i is high while busy_o is low, and the result
// appears on noise_value_o with done_o high for exactly one cycle; the receiver
// cannot hold it off, so it must capture the transfer in that cycle. Each
// active octave runs four scale steps, two passes of the divide-by-three unit
// at four quotient bits per cycle and nine to twelve multiplier and table steps
// per simplex corner.
module fractal_simplex_noise_3d (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [fsn_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [fsn_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic signed [31:0]                     coord_x_i,
  input  logic signed [31:0]                     coord_y_i,
  input  logic signed [31:0]                     coord_z_i,
  output logic                                   done_o,
  output logic signed [31:0]                     noise_value_o
);
  import fsn_pkg::*;

  fsn_state_e state_q, state_d;

  logic [7:0]  seed_q;
  logic [23:0] amp_a_q, freq_a_q, amp_b_q, freq_b_q;
  logic [3:0]  cnt_a_q, cnt_b_q;

  logic             layer_q;
  logic [OCT_W-1:0] oct_q;
  logic [1:0]       corner_q;
  logic             done_q;
  logic signed [31:0] noise_q;

  logic signed [31:0]       cx_q, cy_q, cz_q;
  logic signed [DIV_W-1:0]  sum_q;
  logic [31:0]              ux_q, uy_q, uz_q;
  logic [23:0]              fx_q, fy_q, fz_q;
  logic [7:0]               ii_q, jj_q, kk_q, h_q;
  logic signed [OFS_W-1:0]  x0_q, y0_q, z0_q, px_q, py_q, pz_q;
  logic [2:0]               o1_q, o2_q, hinc_q;
  logic [3:0]               g_q;
  logic [55:0]              dacc_q;
  logic signed [32:0]       t_q;
  logic signed [27:0]       nsum_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic [23:0]            amp_sel, freq_sel;
  logic [3:0]             cnt_sel, oct_lim;
  logic                   layer_run;
  logic [7:0]             s0;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [DIV_W-1:0] u_w, div_val, quo;
  logic                   div_start, div_done;
  logic [55:0]            dsum;
  logic signed [DOT_W-1:0] dot;
  logic [31:0]            vx, vy, vz;
  logic [23:0]            un;
  logic signed [OFS_W-1:0] gofs;
  logic [2:0]             sub;
  logic signed [ACC_W-1:0] term;
  logic signed [32:0]     nv;

  assign amp_sel   = layer_q ? amp_b_q : amp_a_q;
  assign freq_sel  = layer_q ? freq_b_q : freq_a_q;
  assign cnt_sel   = layer_q ? cnt_b_q : cnt_a_q;
  assign oct_lim   = (cnt_sel > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES) : cnt_sel;
  assign layer_run = (amp_sel != '0) && (cnt_sel != '0) && (oct_q < oct_lim);
  assign s0        = seed_q + (layer_q ? LAYER_B_SEED : 8'd0) + 8'(oct_q) + SEED_MIX;

  assign u_w  = DIV_W'(prod >>> (4'd8 - oct_q));
  assign dsum = dacc_q + prod[55:0];
  assign dot  = grad_term(GRAD_X[g_q], px_q) + grad_term(GRAD_Y[g_q], py_q)
              + grad_term(GRAD_Z[g_q], pz_q);
  assign vx   = ux_q + quo[31:0];
  assign vy   = uy_q + quo[31:0];
  assign vz   = uz_q + quo[31:0];
  assign un   = quo[24:1];
  assign term = ACC_W'(prod >>> (6'd24 + 6'(oct_q)));
  assign nv   = 33'(nsum_q) <<< 5;

  fsn_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  fsn_div3 u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_val),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // corner offsets and hash increments
  always_comb begin
    case (corner_q)
      2'd0: begin
        gofs = '0; sub = 3'b000;
      end
      2'd1: begin
        gofs = G3_Q24; sub = o1_q;
      end
      2'd2: begin
        gofs = G3X2_Q24; sub = o2_q;
      end
      default: begin
        gofs = G3X3M1_Q24; sub = 3'b000;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_val   = '0;
    case (state_q)
      ST_IDLE:    if (start_i) state_d = ST_LAYER;
      ST_LAYER: begin
        if (layer_run) begin
          state_d = ST_SCL_X;
        end else if (!layer_q) begin
          state_d = ST_LAYER;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_SCL_X: begin
        mul_a = MUL_W'(cx_q); mul_b = MUL_W'({10'b0, freq_sel}); state_d = ST_SCL_Y;
      end
      ST_SCL_Y: begin
        mul_a = MUL_W'(cy_q); mul_b = MUL_W'({10'b0, freq_sel}); state_d = ST_SCL_Z;
      end
      ST_SCL_Z: begin
        mul_a = MUL_W'(cz_q); mul_b = MUL_W'({10'b0, freq_sel}); state_d = ST_SCL_END;
      end
      ST_SCL_END: begin
        div_start = 1'b1; div_val = sum_q + u_w; state_d = ST_DIV_S;
      end
      ST_DIV_S:   if (div_done) state_d = ST_SKEW;
      ST_SKEW: begin
        div_start = 1'b1;
        div_val   = DIV_W'({2'b0, fx_q}) + DIV_W'({2'b0, fy_q}) + DIV_W'({2'b0, fz_q});
        state_d   = ST_DIV_U;
      end
      ST_DIV_U:   if (div_done) state_d = ST_ORDER;
      ST_ORDER:   state_d = ST_CORNER;
      ST_CORNER:  state_d = ST_HASH0;
      ST_HASH0:   state_d = ST_HASH1;
      ST_HASH1:   state_d = ST_HASH2;
      ST_HASH2:   state_d = ST_DX;
      ST_DX: begin
        mul_a = MUL_W'(px_q); mul_b = MUL_W'(px_q); state_d = ST_DY;
      end
      ST_DY: begin
        mul_a = MUL_W'(py_q); mul_b = MUL_W'(py_q); state_d = ST_DZ;
      end
      ST_DZ: begin
        mul_a = MUL_W'(pz_q); mul_b = MUL_W'(pz_q); state_d = ST_DSUM;
      end
      ST_DSUM:    state_d = ST_FALL;
      ST_FALL: begin
        if (t_q < 0) begin
          state_d = (corner_q == 2'd3) ? ST_WT : ST_CORNER;
        end else begin
          mul_a = MUL_W'(t_q); mul_b = MUL_W'(t_q); state_d = ST_T2;
        end
      end
      ST_T2: begin
        mul_a = MUL_W'({10'b0, prod[47:24]}); mul_b = MUL_W'({10'b0, prod[47:24]});
        state_d = ST_T4;
      end
      ST_T4: begin
        mul_a = MUL_W'({10'b0, prod[47:24]}); mul_b = MUL_W'(dot); state_d = ST_N;
      end
      ST_N:       state_d = (corner_q == 2'd3) ? ST_WT : ST_CORNER;
      ST_WT: begin
        mul_a = MUL_W'(nv); mul_b = MUL_W'({10'b0, amp_sel}); state_d = ST_WTW;
      end
      ST_WTW:     state_d = ST_LAYER;
      ST_OUT:     state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= '0;
      amp_a_q  <= '0;
      freq_a_q <= FREQ_RESET;
      cnt_a_q  <= '0;
      amp_b_q  <= '0;
      freq_b_q <= FREQ_RESET;
      cnt_b_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SEED:   seed_q   <= cfg_data_i[7:0];
        CFG_AMP_A:  amp_a_q  <= cfg_data_i;
        CFG_FREQ_A: freq_a_q <= cfg_data_i;
        CFG_OCT_A:  cnt_a_q  <= cfg_data_i[3:0];
        CFG_AMP_B:  amp_b_q  <= cfg_data_i;
        CFG_FREQ_B: freq_b_q <= cfg_data_i;
        CFG_OCT_B:  cnt_b_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_q  <= 1'b0;
      oct_q    <= '0;
      corner_q <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          layer_q <= 1'b0;
          oct_q   <= '0;
        end
        ST_LAYER: begin
          if (!layer_run && !layer_q) begin
            layer_q <= 1'b1;
            oct_q   <= '0;
          end
        end
        ST_ORDER: corner_q <= '0;
        ST_FALL:  if (t_q < 0) corner_q <= corner_q + 2'd1;
        ST_N:     corner_q <= corner_q + 2'd1;
        ST_WTW:   oct_q <= oct_q + 1'b1;
        ST_OUT:   done_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cx_q  <= coord_x_i;
        cy_q  <= coord_y_i;
        cz_q  <= coord_z_i;
        acc_q <= '0;
      end
      ST_SCL_Y: begin
        sum_q <= u_w;
        ux_q  <= u_w[31:0];
      end
      ST_SCL_Z: begin
        sum_q <= sum_q + u_w;
        uy_q  <= u_w[31:0];
      end
      ST_SCL_END: uz_q <= u_w[31:0];
      ST_DIV_S: begin
        if (div_done) begin
          fx_q <= vx[23:0]; ii_q <= vx[31:24];
          fy_q <= vy[23:0]; jj_q <= vy[31:24];
          fz_q <= vz[23:0]; kk_q <= vz[31:24];
        end
      end
      ST_DIV_U: begin
        if (div_done) begin
          x0_q <= $signed({3'b0, fx_q}) - $signed({3'b0, un});
          y0_q <= $signed({3'b0, fy_q}) - $signed({3'b0, un});
          z0_q <= $signed({3'b0, fz_q}) - $signed({3'b0, un});
        end
      end
      ST_ORDER: begin
        nsum_q <= '0;
        if (x0_q >= y0_q) begin
          if (y0_q >= z0_q) begin
            o1_q <= 3'b100; o2_q <= 3'b110;
          end else if (x0_q >= z0_q) begin
            o1_q <= 3'b100; o2_q <= 3'b101;
          end else begin
            o1_q <= 3'b001; o2_q <= 3'b101;
          end
        end else begin
          if (y0_q < z0_q) begin
            o1_q <= 3'b001; o2_q <= 3'b011;
          end else if (x0_q < z0_q) begin
            o1_q <= 3'b010; o2_q <= 3'b011;
          end else begin
            o1_q <= 3'b010; o2_q <= 3'b110;
          end
        end
      end
      ST_CORNER: begin
        px_q   <= x0_q + gofs - (sub[2] ? ONE_Q24 : '0);
        py_q   <= y0_q + gofs - (sub[1] ? ONE_Q24 : '0);
        pz_q   <= z0_q + gofs - (sub[0] ? ONE_Q24 : '0);
        hinc_q <= (corner_q == 2'd3) ? 3'b111 : sub;
      end
      ST_HASH0: h_q <= PERM[kk_q + 8'(hinc_q[0])];
      ST_HASH1: h_q <= PERM[jj_q + 8'(hinc_q[1]) + h_q];
      ST_HASH2: g_q <= 4'(PERM[ii_q + 8'(hinc_q[2]) + h_q] ^ s0);
      ST_DY:    dacc_q <= prod[55:0];
      ST_DZ:    dacc_q <= dsum;
      ST_DSUM:  t_q <= FALLOFF_Q24 - $signed({1'b0, dsum[55:24]});
      ST_N:     nsum_q <= nsum_q + 28'(prod >>> 24);
      ST_WTW:   acc_q <= acc_q + term;
      ST_OUT: begin
        if (acc_q > ACC_W'(32'sh7FFFFFFF)) begin
          noise_q <= 32'sh7FFFFFFF;
        end else if (acc_q < -ACC_W'(36'sh080000000)) begin
          noise_q <= 32'sh80000000;
        end else begin
          noise_q <= acc_q[31:0];
        end
      end
      default: ;
    endcase
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign noise_value_o = noise_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted point did not start the sequencer");

  a_done_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_OUT))
    else $error("result strobe without final state");

  a_octave_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oct_q <= 4'(MAX_OCTAVES))
    else $error("octave counter ran past its limit");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_S || state_q == ST_DIV_U))
    else $error("divider finished outside a wait state");

endmodule

>>> sim/fractal_simplex_noise_3d_tb.sv
// ----------------------------------------------------------------------------
// fractal_simplex_noise_3d_tb: self-checking bench for the fractal noise block
// points are driven through the start/busy port under several register
// settings; a fixed-point noise predictor computes each expected value and
// every done transfer is compared with the oldest one still waiting
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fractal_simplex_noise_3d_tb;
  import fsn_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic start_i;
  logic busy_o;
  logic signed [31:0] coord_x_i, coord_y_i, coord_z_i;
  logic done_o;
  logic signed [31:0] noise_value_o;

  fractal_simplex_noise_3d DUT (.*);

  // predictor copy of the registers
  logic [7:0]  seed_r   = 8'd0;
  logic [23:0] amp_a_r  = 24'd0;
  logic [23:0] freq_a_r = FREQ_RESET;
  logic [3:0]  oct_a_r  = 4'd0;
  logic [23:0] amp_b_r  = 24'd0;
  logic [23:0] freq_b_r = FREQ_RESET;
  logic [3:0]  oct_b_r  = 4'd0;

  point_t              pending_points[$];
  logic signed [31:0]  expected_noise[$];
  int unsigned         send_idle_pct;
  logic                hold_off;
  int unsigned         issued_cnt, accepted_cnt, cycle_cnt;
  bit                  failed;

  function automatic longint scaled_coord(longint c, logic [23:0] freq, int o);
    longint u;
    u = (c * longint'(freq)) >>> (8 - o);
    if (u > (64'sd1 <<< 61)) u = 64'sd1 <<< 61;
    if (u < -(64'sd1 <<< 61)) u = -(64'sd1 <<< 61);
    return u;
  endfunction

  function automatic longint corner_term(longint x, longint y, longint z, int unsigned h);
    longint d, t, t2, t4, dot;
    d = (x * x + y * y + z * z) >>> 24;
    t = longint'(FALLOFF_Q24) - d;
    if (t < 0) return 0;
    t2 = (t * t) >>> 24;
    t4 = (t2 * t2) >>> 24;
    dot = longint'(GRAD_X[h & 15]) * x + longint'(GRAD_Y[h & 15]) * y
        + longint'(GRAD_Z[h & 15]) * z;
    return (t4 * dot) >>> 24;
  endfunction

  function automatic int unsigned perm_hash(int unsigned a, int unsigned b, int unsigned c,
                                            logic [7:0] s0);
    int unsigned h;
    h = PERM[c & 255];
    h = PERM[(b + h) & 255];
    h = PERM[(a + h) & 255];
    return h ^ s0;
  endfunction

  function automatic longint simplex_q24(longint ux, longint uy, longint uz, logic [7:0] s0);
    longint v, s, i, j, k, fx, fy, fz, un, x0, y0, z0, acc;
    int a1, b1, c1, a2, b2, c2;
    int unsigned ii, jj, kk;
    v = ux + uy + uz;
    s = v / 3;
    if ((v % 3) != 0 && v < 0) s--;
    i = (ux + s) >>> 24;
    j = (uy + s) >>> 24;
    k = (uz + s) >>> 24;
    fx = ux + s - (i <<< 24);
    fy = uy + s - (j <<< 24);
    fz = uz + s - (k <<< 24);
    un = (fx + fy + fz) / 6;
    x0 = fx - un; y0 = fy - un; z0 = fz - un;
    ii = int'(i & 255); jj = int'(j & 255); kk = int'(k & 255);
    if (x0 >= y0) begin
      if (y0 >= z0) begin a1 = 1; b1 = 0; c1 = 0; a2 = 1; b2 = 1; c2 = 0; end
      else if (x0 >= z0) begin a1 = 1; b1 = 0; c1 = 0; a2 = 1; b2 = 0; c2 = 1; end
      else begin a1 = 0; b1 = 0; c1 = 1; a2 = 1; b2 = 0; c2 = 1; end
    end else begin
      if (y0 < z0) begin a1 = 0; b1 = 0; c1 = 1; a2 = 0; b2 = 1; c2 = 1; end
      else if (x0 < z0) begin a1 = 0; b1 = 1; c1 = 0; a2 = 0; b2 = 1; c2 = 1; end
      else begin a1 = 0; b1 = 1; c1 = 0; a2 = 1; b2 = 1; c2 = 0; end
    end
    acc = corner_term(x0, y0, z0, perm_hash(ii, jj, kk, s0));
    acc += corner_term(x0 - a1 * 64'sd16777216 + G3_Q24, y0 - b1 * 64'sd16777216 + G3_Q24,
                       z0 - c1 * 64'sd16777216 + G3_Q24,
                       perm_hash(ii + a1, jj + b1, kk + c1, s0));
    acc += corner_term(x0 - a2 * 64'sd16777216 + G3X2_Q24,
                       y0 - b2 * 64'sd16777216 + G3X2_Q24,
                       z0 - c2 * 64'sd16777216 + G3X2_Q24,
                       perm_hash(ii + a2, jj + b2, kk + c2, s0));
    acc += corner_term(x0 + G3X3M1_Q24, y0 + G3X3M1_Q24, z0 + G3X3M1_Q24,
                       perm_hash(ii + 1, jj + 1, kk + 1, s0));
    return acc * 32;
  endfunction

  function automatic longint layer_sum(point_t p, logic [23:0] amp, logic [23:0] freq,
                                       logic [3:0] cnt, logic [7:0] seed_off);
    longint acc, nv;
    int n;
    logic [7:0] s0;
    acc = 0;
    if (amp == 0 || cnt == 0) return 0;
    n = (cnt > MAX_OCTAVES) ? MAX_OCTAVES : cnt;
    for (int o = 0; o < n; o++) begin
      s0 = seed_r + seed_off + 8'(o) + SEED_MIX;
      nv = simplex_q24(scaled_coord(p.x, freq, o), scaled_coord(p.y, freq, o),
                       scaled_coord(p.z, freq, o), s0);
      acc += (nv * longint'(amp)) >>> (24 + o);
    end
    return acc;
  endfunction

  function automatic logic signed [31:0] fractal_noise(point_t p);
    longint r;
    r = layer_sum(p, amp_a_r, freq_a_r, oct_a_r, 8'd0)
      + layer_sum(p, amp_b_r, freq_b_r, oct_b_r, LAYER_B_SEED);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return 32'(r);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // driver
  always @(negedge clk_i) begin
    if (start_i && accepted_cnt != issued_cnt) begin
      // still waiting for the transfer
    end else if (pending_points.size() > 0 && !hold_off &&
                 $urandom_range(99) >= send_idle_pct) begin
      point_t p;
      p = pending_points.pop_front();
      start_i   <= 1'b1;
      coord_x_i <= p.x;
      coord_y_i <= p.y;
      coord_z_i <= p.z;
      issued_cnt <= issued_cnt + 1;
    end else begin
      start_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("fractal_simplex_noise_3d: mismatch");
      $finish;
    end
    if (rst_ni && start_i && !busy_o) begin
      expected_noise.insert(expected_noise.size(),
                            fractal_noise('{coord_x_i, coord_y_i, coord_z_i}));
      accepted_cnt <= accepted_cnt + 1;
    end
    if (rst_ni && done_o) begin
      if (expected_noise.size() == 0) begin
        $display("%0t: noise_value with nothing expected, actual %0d", $time, noise_value_o);
        failed = 1'b1;
      end else begin
        logic signed [31:0] e;
        e = expected_noise.pop_front();
        if (e !== noise_value_o) begin
          $display("%0t: noise_value expected %0d actual %0d", $time, e, noise_value_o);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_SEED:   seed_r   = data[7:0];
      CFG_AMP_A:  amp_a_r  = data;
      CFG_FREQ_A: freq_a_r = data;
      CFG_OCT_A:  oct_a_r  = data[3:0];
      CFG_AMP_B:  amp_b_r  = data;
      CFG_FREQ_B: freq_b_r = data;
      CFG_OCT_B:  oct_b_r  = data[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_layers(logic [7:0] sd, logic [23:0] aa, logic [23:0] fa, logic [3:0] oa,
                            logic [23:0] ab, logic [23:0] fb, logic [3:0] ob);
    write_reg(CFG_SEED, 24'(sd));
    write_reg(CFG_AMP_A, aa);
    write_reg(CFG_FREQ_A, fa);
    write_reg(CFG_OCT_A, 24'(oa));
    write_reg(CFG_AMP_B, ab);
    write_reg(CFG_FREQ_B, fb);
    write_reg(CFG_OCT_B, 24'(ob));
  endtask

  task automatic wait_results();
    while (start_i || expected_noise.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_points.size() > 0 || start_i || expected_noise.size() > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(2))
      0: return $urandom;
      1: return $signed($urandom_range(32'h7FFFF)) - 32'sh40000;
      default: return $signed($urandom_range(32'h3FFFFFF)) - 32'sh2000000;
    endcase
  endfunction

  task automatic add_point(logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z);
    pending_points.insert(pending_points.size(), '{x, y, z});
  endtask

  initial begin
    logic signed [31:0] edge_vals[8];
    int n_items;
    edge_vals = '{32'sh0, 32'sh7FFFFFFF, -32'sh80000000, 32'sh1, -32'sh1,
                  32'sh10000, -32'sh10000, 32'sh8000};
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0; start_i = 1'b0;
    coord_x_i = '0; coord_y_i = '0; coord_z_i = '0;
    send_idle_pct = 24; hold_off = 1'b0; failed = 1'b0;
    issued_cnt = 0; accepted_cnt = 0; cycle_cnt = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: both layers off
    add_point(32'sh12345, -32'sh5432, 32'sh7FFFFFFF);
    add_point(-32'sh80000000, 32'sh0, 32'sh1);
    wait_drained();

    // extremes, octave clamp and an unused register index
    set_layers(8'hFF, 24'hFFFFFF, 24'h010000, 4'd1, 24'h010000, 24'hFFFFFF, 4'd15);
    write_reg(CFG_UNUSED, 24'hFFFFFF);
    for (int k = 0; k < 8; k++)
      add_point(edge_vals[k], edge_vals[(k + 3) % 8], edge_vals[(k + 5) % 8]);
    wait_drained();

    // zero frequency samples the origin on every octave
    set_layers(8'h00, 24'h024000, 24'h0, 4'd3, 24'h000001, 24'h0, 4'd2);
    for (int k = 0; k < 4; k++) add_point(edge_vals[k], edge_vals[7 - k], $urandom);
    wait_drained();

    set_layers(8'h5A, 24'h800000, 24'h018000, 4'd8, 24'h7FFFFF, 24'h004000, 4'd8);
    for (int k = 0; k < 6; k++) add_point(rand_coord(), rand_coord(), rand_coord());
    wait_drained();

    for (int ph = 0; ph < 13; ph++) begin
      send_idle_pct = (ph < 4) ? 24 : (ph < 8) ? 60 : 0;
      set_layers(8'($urandom), ($urandom_range(3) == 0) ? 24'h0 : 24'($urandom),
                 ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(24'h40000)),
                 4'($urandom_range(3)), 24'($urandom),
                 24'($urandom_range(24'h80000)), 4'($urandom_range(2)));
      n_items = (ph == 12) ? 36 : 112;
      for (int k = 0; k < n_items; k++) begin
        add_point(rand_coord(), rand_coord(), rand_coord());
        if (ph == 5 && k == 50) begin
          while (pending_points.size() > 0) @(posedge clk_i);
          hold_off = 1'b1;
          wait_results();
          hold_off = 1'b0;
        end
      end
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (!failed) begin
      $display("fractal_simplex_noise_3d: match");
    end else begin
      $display("fractal_simplex_noise_3d: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/fsn_pkg.sv
rtl/fsn_mul.sv
rtl/fsn_div3.sv
rtl/fractal_simplex_noise_3d.sv
sim/fractal_simplex_noise_3d_tb.sv
